/* hw/rtl/k_way_max_merge_defines.svh */
// Assertion macros shared by the merge engine
`ifndef K_WAY_MAX_MERGE_DEFINES_SVH
`define K_WAY_MAX_MERGE_DEFINES_SVH

// Same-cycle implication
`define KWM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/kwm_pkg.sv */
package kwm_pkg;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] STAT_PUSH_OK = 2'd0;
  localparam logic [1:0] STAT_POPPED  = 2'd1;
  localparam logic [1:0] STAT_DONE    = 2'd2;
  localparam logic [1:0] STAT_REJECT  = 2'd3;

  localparam logic [3:0] ACTIVE_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SCAN,
    ST_DRAIN,
    ST_POP
  } kwm_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic push_commit;
    logic pop_commit;
  } kwm_ctl_t;

  typedef struct packed {
    logic scan_last;
  } kwm_stat_t;

endpackage

/* hw/rtl/kwm_ctrl.sv */
module kwm_ctrl
  import kwm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      cmd,
  input  kwm_stat_t stat,
  output logic      busy,
  output kwm_ctl_t  ctl
);

  kwm_state_t state;
  kwm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (cmd == CMD_POP) ? ST_SCAN : ST_PUSH;
        end
      end
      ST_PUSH:  state_next = ST_IDLE;
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_POP;
      ST_POP:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy            = (state != ST_IDLE);
    ctl.load        = start && (state == ST_IDLE);
    ctl.scan        = (state == ST_SCAN);
    ctl.push_commit = (state == ST_PUSH);
    ctl.pop_commit  = (state == ST_POP);
  end

endmodule

/* hw/rtl/kwm_datapath.sv */
`include "k_way_max_merge_defines.svh"

module kwm_datapath
  import kwm_pkg::*;
#(
  parameter int WAYS  = 8,
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  kwm_ctl_t    ctl,
  output kwm_stat_t   stat,
  input  logic [2:0]  way,
  input  logic [30:0] value,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [30:0] out_value
);

  localparam int WIDX = $clog2(WAYS);
  localparam int PW   = $clog2(DEPTH);
  localparam int PW1  = PW + 1;
  localparam int FW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(WAYS * DEPTH);

  logic [3:0]      active_ways;
  logic [2:0]      way_q;
  logic [30:0]     value_q;
  logic [WIDX-1:0] scan_idx;
  logic            pipe_valid;
  logic [WIDX-1:0] pipe_way;
  logic [30:0]     best;
  logic [WIDX-1:0] best_way;
  logic [30:0]     rdata;
  logic [PW-1:0]   rp [WAYS];
  logic [FW-1:0]   fc [WAYS];
  logic [30:0]     mem [WAYS*DEPTH];

  logic [WIDX-1:0] last_way;
  logic [WIDX-1:0] sel_idx;
  logic [PW-1:0]   sel_rp;
  logic [FW-1:0]   sel_fc;
  logic            push_bad;
  logic [PW:0]     tail_sum;
  logic [PW-1:0]   tail;
  logic [PW-1:0]   rp_inc;
  logic [PW-1:0]   mem_ptr;
  logic [AW-1:0]   mem_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_ways <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_ways <= cfg_data;
    end
  end

  always_comb begin
    if (active_ways == 4'd0) begin
      last_way = '0;
    end else if (32'(active_ways) >= WAYS) begin
      last_way = WIDX'(WAYS - 1);
    end else begin
      last_way = WIDX'(active_ways - 4'd1);
    end
  end

  always_comb begin
    priority if (ctl.scan) begin
      sel_idx = scan_idx;
    end else if (ctl.pop_commit) begin
      sel_idx = best_way;
    end else begin
      sel_idx = WIDX'(way_q);
    end
  end

  assign sel_rp   = rp[sel_idx];
  assign sel_fc   = fc[sel_idx];
  assign push_bad = (32'(way_q) > 32'(last_way)) || (value_q == '0) ||
                    (sel_fc == FW'(DEPTH));
  assign tail_sum = {1'b0, sel_rp} + PW1'(sel_fc);
  assign tail     = (tail_sum >= PW1'(DEPTH)) ? PW'(tail_sum - PW1'(DEPTH)) : PW'(tail_sum);
  assign rp_inc   = (sel_rp == PW'(DEPTH - 1)) ? '0 : sel_rp + 1'b1;
  assign mem_ptr  = ctl.push_commit ? tail : sel_rp;
  assign mem_addr = AW'(sel_idx) * AW'(DEPTH) + AW'(mem_ptr);

  assign stat.scan_last = (scan_idx == last_way);

  always_ff @(posedge clk) begin
    if (ctl.push_commit && !push_bad) begin
      mem[mem_addr] <= value_q;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WAYS; i++) begin
        rp[i] <= '0;
        fc[i] <= '0;
      end
    end else if (ctl.push_commit && !push_bad) begin
      fc[sel_idx] <= sel_fc + 1'b1;
    end else if (ctl.pop_commit && (best != '0)) begin
      rp[sel_idx] <= rp_inc;
      fc[sel_idx] <= sel_fc - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= ctl.scan && (sel_fc != '0);
    end
  end

  always_ff @(posedge clk) begin
    pipe_way <= scan_idx;
    if (ctl.load) begin
      way_q    <= way;
      value_q  <= value;
      scan_idx <= '0;
      best     <= '0;
      best_way <= '0;
    end else begin
      if (ctl.scan) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (pipe_valid && (rdata > best)) begin
        best     <= rdata;
        best_way <= pipe_way;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.push_commit || ctl.pop_commit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push_commit) begin
      status    <= push_bad ? STAT_REJECT : STAT_PUSH_OK;
      out_value <= '0;
    end else if (ctl.pop_commit) begin
      status    <= (best == '0) ? STAT_DONE : STAT_POPPED;
      out_value <= best;
    end
  end

  `KWM_ASSERT_NEXT(a_word_follows_commit, clk, rst, ctl.push_commit || ctl.pop_commit,
                   done, "result word missing after commit")
  `KWM_ASSERT_IMPLY(a_zero_unless_popped, clk, rst, done && (status != STAT_POPPED),
                    out_value == '0, "nonzero value on non-pop word")
  `KWM_ASSERT_IMPLY(a_popped_nonzero, clk, rst, done && (status == STAT_POPPED),
                    out_value != '0, "popped word carries zero")
  `KWM_ASSERT_IMPLY(a_fill_bounded, clk, rst, ctl.push_commit || ctl.pop_commit,
                    sel_fc <= FW'(DEPTH), "fill count above depth")

endmodule

/* hw/rtl/k_way_max_merge.sv */
// Push: accepted at start, committed in the push state, result word strobed on done after it.
// Pop: reads one way head per cycle from the shared store, then compares and commits;
//   the scan covers the active ways (at least one, at most WAYS); result word strobed on done after the pop state.
// A new item is taken while the previous result word is on done; no stall from the receiver.
// Synchronous active-high rst clears control, fill counts, read pointers; active_ways -> 8.
module k_way_max_merge
  import kwm_pkg::*;
#(
  parameter int WAYS  = 8,
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [2:0]  way,
  input  logic [30:0] value,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [30:0] out_value
);

  kwm_ctl_t  ctl;
  kwm_stat_t stat;

  kwm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  kwm_datapath #(
    .WAYS  (WAYS),
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .way       (way),
    .value     (value),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .done      (done),
    .status    (status),
    .out_value (out_value)
  );

endmodule

/* bench/k_way_max_merge_test.sv */
module k_way_max_merge_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kwm_pkg::*;

  localparam int NWAYS = 8;
  localparam int FIFO_DEPTH = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int WORDS_PER_PHASE = 110;

  class merge_scoreboard;
    logic [30:0] ring [NWAYS][FIFO_DEPTH];
    bit [5:0] head [NWAYS];
    int unsigned fill [NWAYS];
    bit [3:0] active;
    bit [1:0] want_status[$];
    bit [30:0] want_value[$];
    int errors;

    function new();
      foreach (head[i]) begin
        head[i] = '0;
        fill[i] = 0;
      end
      active = ACTIVE_RESET;
      errors = 0;
    endfunction

    function void write_active(bit [3:0] v);
      active = v;
    endfunction

    function int unsigned live();
      if (active == 0) return 1;
      if (active > NWAYS) return NWAYS;
      return active;
    endfunction

    function int pending();
      return want_status.size();
    endfunction

    function void note_item(logic c, logic [2:0] w, logic [30:0] v);
      int unsigned n;
      int unsigned pick;
      bit [30:0] best;
      bit [1:0] st;
      n = live();
      best = '0;
      pick = 0;
      if (c == CMD_PUSH) begin
        if (w >= n || v == 0 || fill[w] >= FIFO_DEPTH) begin
          st = STAT_REJECT;
        end else begin
          ring[w][6'(head[w] + fill[w])] = v;
          fill[w]++;
          st = STAT_PUSH_OK;
        end
      end else begin
        for (int i = 0; i < n; i++) begin
          if (fill[i] != 0 && ring[i][head[i]] > best) begin
            best = ring[i][head[i]];
            pick = i;
          end
        end
        if (best == 0) begin
          st = STAT_DONE;
        end else begin
          head[pick]++;
          fill[pick]--;
          st = STAT_POPPED;
        end
      end
      want_status.push_back(st);
      want_value.push_back(best);
    endfunction

    function void check_result(logic [1:0] s, logic [30:0] v);
      bit [1:0] ws;
      bit [30:0] wv;
      if (want_status.size() == 0) begin
        $error("result word with none expected: status=%0d out_value=%0h", s, v);
        errors++;
        return;
      end
      ws = want_status.pop_front();
      wv = want_value.pop_front();
      if (s !== ws) begin
        $error("status: expected %0d, actual %0d", ws, s);
        errors++;
      end
      if (v !== wv) begin
        $error("out_value: expected %0h, actual %0h", wv, v);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cmd = CMD_PUSH;
  logic [2:0] way = '0;
  logic [30:0] value = '0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_data = '0;
  logic done;
  logic [1:0] status;
  logic [30:0] out_value;

  merge_scoreboard sb;
  int cycles = 0;
  int words_sent = 0;
  bit quiet = 1'b0;

  k_way_max_merge u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .way(way),
    .value(value),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .done(done),
    .status(status),
    .out_value(out_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(status, out_value);
      if (start && !busy) sb.note_item(cmd, way, value);
    end
  end

  task automatic idle_gap();
    int g;
    int r;
    g = 0;
    if (!quiet) begin
      r = $urandom_range(0, 99);
      if (r >= 93) g = $urandom_range(8, 40);
      else if (r >= 65) g = $urandom_range(1, 3);
    end
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_word(logic c, logic [2:0] w, logic [30:0] v);
    idle_gap();
    start <= 1'b1;
    cmd <= c;
    way <= w;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  task automatic push(logic [2:0] w, logic [30:0] v);
    send_word(CMD_PUSH, w, v);
  endtask

  task automatic pop();
    send_word(CMD_POP, 3'($urandom), 31'($urandom));
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_active(logic [3:0] v);
    quiesce();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_active(v);
  endtask

  // push a non-increasing list into each live way (at times an inactive one too), then pop the merge back out
  task automatic merge_round();
    int unsigned n_live;
    int total;
    int len;
    logic [30:0] v;
    logic [30:0] tie_seed;
    n_live = sb.live();
    total = 0;
    tie_seed = 31'($urandom_range(1, 32'h7fffffff));
    for (int w = 0; w < NWAYS; w++) begin
      if (w >= n_live && $urandom_range(0, 3) != 0) continue;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) v = tie_seed;
      else if ($urandom_range(0, 4) == 0) v = 31'($urandom_range(1, 40));
      else v = 31'($urandom_range(1, 32'h7fffffff));
      repeat (len) begin
        if ($urandom_range(0, 32) == 0) begin
          push(3'(w), '0);
        end else begin
          push(3'(w), v);
          if (w < n_live) total++;
        end
        v = v - 31'($urandom_range(0, v / (len + 1)));
      end
    end
    repeat (total + $urandom_range(1, 2)) pop();
  endtask

  task automatic noise_burst();
    logic [30:0] v;
    int r;
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 9);
      if (r == 0) v = '0;
      else if (r < 4) v = 31'($urandom_range(1, 20));
      else v = 31'($urandom);
      send_word(1'($urandom), 3'($urandom), v);
    end
  endtask

  initial begin
    logic [3:0] settings [10];
    int phase_end;
    sb = new();
    settings = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd8, 4'd5, 4'd2, 4'd7, 4'd8};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    pop();
    push(3'd0, '0);
    push(3'd7, 31'h7fffffff);
    push(3'd0, 31'd1);
    push(3'd3, 31'h55555555);
    push(3'd5, 31'h2aaaaaaa);
    push(3'd6, 31'h2aaaaaaa);
    push(3'd2, 31'd1000);
    push(3'd4, 31'd1000);
    repeat (8) pop();

    set_active(4'd0);
    push(3'd1, 31'd5);
    push(3'd0, 31'd9);
    pop();
    pop();

    set_active(4'd15);
    push(3'd6, 31'd123);
    set_active(4'd2);
    pop();
    push(3'd6, 31'd7);
    set_active(4'd8);
    pop();
    pop();

    foreach (settings[p]) begin
      set_active(settings[p]);
      quiet = (p % 3 == 1);
      phase_end = words_sent + WORDS_PER_PHASE;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 99) < 65) merge_round();
        else noise_burst();
      end
    end

    quiesce();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
